### src/hspd_pkg.sv
package hspd_pkg;

	localparam int PosW = 35;
	localparam int RotW = 32;
	localparam int AngW = 20;
	localparam int VelW = 29;
	localparam int CprW = 11;
	localparam int StepW = 25;
	localparam int CfgW = 32;
	localparam int CfgIdxW = 2;
	localparam int QDepthDefault = 2;
	localparam logic [7:0] PolePairsReset = 8'd7;
	localparam logic [24:0] AngleStepReset = 25'd2509866;
	localparam logic [31:0] SectorTableReset = 32'hF312540F;
	localparam logic signed [AngW-1:0] AngLimit = 20'sd411775;
	localparam logic [VelW-2:0] VelLimit = 28'd268435455;

	localparam logic [CfgIdxW-1:0] RegPolePairs = 2'd0;
	localparam logic [CfgIdxW-1:0] RegAngleStep = 2'd1;
	localparam logic [CfgIdxW-1:0] RegSectorTable = 2'd2;

	localparam logic [1:0] DirUnknown = 2'd0;
	localparam logic [1:0] DirCw = 2'd1;
	localparam logic [1:0] DirCcw = 2'd2;

	typedef struct packed {
		logic accepted;
		logic signed [3:0] sector;
		logic [1:0] turn_direction;
		logic signed [PosW-1:0] position_count;
		logic [31:0] edge_count;
		logic vel_zero;
		logic [31:0] interval;
	} snap_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_POS,
		ST_MUL_ANG,
		ST_DIV_VEL,
		ST_DONE
	} back_state_t;

endpackage

### src/hspd_front.sv
module hspd_front import hspd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic cmd,
	input  logic hall_a,
	input  logic hall_b,
	input  logic hall_c,
	input  logic [31:0] now_us,
	input  logic [31:0] sector_table,
	output snap_t snap
);

	logic [2:0] last_hall_q;
	logic signed [3:0] cur_sector_q;
	logic [31:0] rotations_q;
	logic [1:0] dir_now_q;
	logic [1:0] dir_before_q;
	logic [31:0] last_edge_q;
	logic [31:0] interval_q;
	logic [31:0] edges_q;

	logic [2:0] hs;
	logic change;
	logic signed [3:0] ns;
	logic signed [4:0] diff;
	logic [1:0] dir_n;
	logic [31:0] rot_n;
	logic signed [3:0] sec_v;
	logic [31:0] rot_v;
	logic [1:0] dir_v;
	logic [31:0] lt_v;
	logic [31:0] iv_v;
	logic [31:0] ed_v;
	logic [31:0] elapsed;
	logic [32:0] twice;

	assign hs = {hall_a, hall_b, hall_c};
	assign change = !cmd && (hs != last_hall_q);
	assign ns = sector_table[{hs, 2'b00} +: 4];
	assign diff = 5'(ns) - 5'(cur_sector_q);

	always_comb begin
		rot_n = rotations_q;
		if (diff > 5'sd3) begin
			dir_n = DirCcw;
			rot_n = rotations_q - 32'd1;
		end else if (diff < -5'sd3) begin
			dir_n = DirCw;
			rot_n = rotations_q + 32'd1;
		end else begin
			dir_n = (ns > cur_sector_q) ? DirCw : DirCcw;
		end
		if (change) begin
			sec_v = ns;
			rot_v = rot_n;
			dir_v = dir_n;
			lt_v = now_us;
			iv_v = (dir_n == dir_before_q) ? (now_us - last_edge_q) : 32'd0;
			ed_v = edges_q + 32'd1;
		end else begin
			sec_v = cur_sector_q;
			rot_v = rotations_q;
			dir_v = dir_now_q;
			lt_v = last_edge_q;
			iv_v = interval_q;
			ed_v = edges_q;
		end
		elapsed = now_us - lt_v;
		twice = {iv_v, 1'b0};
		snap.accepted = change;
		snap.sector = sec_v;
		snap.turn_direction = dir_v;
		snap.position_count = PosW'($signed(rot_v)) * 35'sd6 + PosW'(sec_v);
		snap.edge_count = ed_v;
		snap.interval = iv_v;
		snap.vel_zero = (iv_v == 32'd0) || (dir_v == DirUnknown) ||
			({1'b0, elapsed} > twice);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_hall_q <= '0;
			cur_sector_q <= '0;
			rotations_q <= '0;
			dir_now_q <= DirUnknown;
			dir_before_q <= DirUnknown;
			last_edge_q <= '0;
			interval_q <= '0;
			edges_q <= '0;
		end else if (in_valid && change) begin
			last_hall_q <= hs;
			cur_sector_q <= sec_v;
			rotations_q <= rot_v;
			dir_now_q <= dir_v;
			dir_before_q <= dir_v;
			last_edge_q <= lt_v;
			interval_q <= iv_v;
			edges_q <= ed_v;
		end
	end

endmodule

### src/hspd_queue.sv
module hspd_queue import hspd_pkg::*; #(
	parameter int Depth = QDepthDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  snap_t wdata,
	output logic full,
	input  logic rd,
	output logic empty,
	output snap_t rdata
);

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

	snap_t mem_q [Depth];
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [AW:0] cnt_q;

	assign full = (cnt_q == (AW+1)'(Depth));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !full) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr && !full) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + AW'(1);
			if (rd && !empty) rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(wr && !full) - (AW+1)'(rd && !empty);
		end
	end

endmodule

### src/hspd_back.sv
module hspd_back import hspd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_empty,
	input  snap_t in_snap,
	output logic in_pop,
	input  logic [7:0] pole_pairs,
	input  logic [24:0] angle_step,
	output logic out_valid,
	input  logic out_pop,
	output logic accepted,
	output logic signed [3:0] sector,
	output logic [1:0] turn_direction,
	output logic signed [PosW-1:0] position_count,
	output logic signed [RotW-1:0] whole_turns,
	output logic signed [AngW-1:0] angle_q16,
	output logic signed [VelW-1:0] velocity_q8,
	output logic [31:0] edge_count
);

	localparam int NumW = 45;
	localparam int DenW = 48;
	localparam int CntW = 6;

	back_state_t state_q, state_d;
	snap_t snap_q;
	logic [NumW-1:0] num_q;
	logic [DenW+NumW-1:0] rem_q;
	logic [CntW-1:0] cnt_q;
	logic neg_q;
	logic [CprW-1:0] cpr;
	logic [PosW-1:0] pos_mag;
	logic [DenW:0] trial;
	logic [DenW-1:0] den;
	logic signed [CprW:0] srem_q;
	logic signed [CprW+StepW+1:0] prod_q;
	logic signed [CprW+StepW+1:0] ang_sh;
	logic out_valid_q;
	logic start, div_done;

	assign cpr = (pole_pairs == 8'd0) ? CprW'(6) : CprW'(pole_pairs) * CprW'(6);
	assign pos_mag = snap_q.position_count[PosW-1] ? PosW'(-snap_q.position_count)
		: PosW'(snap_q.position_count);
	assign den = (state_q == ST_DIV_POS) ? DenW'(cpr) : {snap_q.interval, 16'd0};
	assign trial = {1'b0, rem_q[DenW+NumW-2 -: DenW]} - {1'b0, den};
	assign start = (state_q == ST_IDLE) && !in_empty && !out_valid_q;
	assign div_done = (cnt_q == CntW'(NumW));
	assign in_pop = start;
	assign out_valid = out_valid_q;
	assign ang_sh = prod_q >>> 8;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (start) state_d = ST_DIV_POS;
			ST_DIV_POS: if (div_done) state_d = ST_MUL_ANG;
			ST_MUL_ANG: state_d = snap_q.vel_zero ? ST_DONE : ST_DIV_VEL;
			ST_DIV_VEL: if (div_done) state_d = ST_DONE;
			ST_DONE:    state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE) out_valid_q <= 1'b1;
			else if (out_pop && out_valid_q) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				snap_q <= in_snap;
				cnt_q <= '0;
				rem_q <= '0;
			end
			ST_DIV_POS: begin
				if (cnt_q == '0) begin
					rem_q <= {{DenW{1'b0}}, NumW'(pos_mag)};
					neg_q <= snap_q.position_count[PosW-1];
				end else if (!trial[DenW]) begin
					rem_q <= {trial[DenW-1:0], rem_q[NumW-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[DenW+NumW-2:0], 1'b0};
				end
				if (div_done) begin
					whole_turns <= neg_q ? -32'(rem_q[NumW-2:0] << 1 | 32'(!trial[DenW]))
						: 32'(rem_q[NumW-2:0] << 1 | 32'(!trial[DenW]));
					srem_q <= neg_q ? -$signed({1'b0, CprW'(trial[DenW] ?
						rem_q[DenW+NumW-2 -: DenW] : trial[DenW-1:0])})
						: $signed({1'b0, CprW'(trial[DenW] ?
						rem_q[DenW+NumW-2 -: DenW] : trial[DenW-1:0])});
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_q + CntW'(1);
				end
			end
			ST_MUL_ANG: begin
				prod_q <= (CprW+StepW+2)'(srem_q) * $signed({1'b0, angle_step});
			end
			ST_DIV_VEL: begin
				if (cnt_q == '0) begin
					rem_q <= {{DenW{1'b0}}, NumW'(angle_step) * NumW'(1000000)};
					cnt_q <= cnt_q + CntW'(1);
				end else begin
					if (!trial[DenW]) rem_q <= {trial[DenW-1:0], rem_q[NumW-2:0], 1'b1};
					else rem_q <= {rem_q[DenW+NumW-2:0], 1'b0};
					cnt_q <= cnt_q + CntW'(1);
				end
			end
			ST_DONE: begin
				if (ang_sh > (CprW+StepW+2)'(AngLimit)) angle_q16 <= AngLimit;
				else if (ang_sh < -(CprW+StepW+2)'(AngLimit)) angle_q16 <= -AngLimit;
				else angle_q16 <= AngW'(ang_sh);
				if (!snap_q.vel_zero) begin
					if (rem_q[NumW-1:0] > NumW'(VelLimit))
						velocity_q8 <= (snap_q.turn_direction == DirCcw) ?
							-VelW'(VelLimit) : VelW'(VelLimit);
					else
						velocity_q8 <= (snap_q.turn_direction == DirCcw) ?
							-VelW'(rem_q[NumW-1:0]) : VelW'(rem_q[NumW-1:0]);
				end else begin
					velocity_q8 <= '0;
				end
				accepted <= snap_q.accepted;
				sector <= snap_q.sector;
				turn_direction <= snap_q.turn_direction;
				position_count <= snap_q.position_count;
				edge_count <= snap_q.edge_count;
			end
			default: begin
			end
		endcase
	end

endmodule

### src/hall_sensor_position_decoder_unit.sv
// The result is formed by two shift-subtract divisions (position by counts per revolution,
// then velocity); the velocity division is skipped when velocity is zero.
// The back end takes a new beat only once the last result has been popped.
// A queue (QueueDepth entries, two by default) sits between the classifying front and the arithmetic back.
// Reset is asynchronous and active low; it clears the control state and restores the registers.
module hall_sensor_position_decoder_unit import hspd_pkg::*; #(
	parameter int QueueDepth = QDepthDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [CfgW-1:0] cfg_data,
	input  logic push,
	output logic full,
	input  logic cmd,
	input  logic hall_a,
	input  logic hall_b,
	input  logic hall_c,
	input  logic [31:0] now_us,
	output logic empty,
	input  logic pop,
	output logic accepted,
	output logic signed [3:0] sector,
	output logic [1:0] turn_direction,
	output logic signed [PosW-1:0] position_count,
	output logic signed [RotW-1:0] whole_turns,
	output logic signed [AngW-1:0] angle_q16,
	output logic signed [VelW-1:0] velocity_q8,
	output logic [31:0] edge_count
);

	logic [7:0] pole_pairs_q;
	logic [24:0] angle_step_q;
	logic [31:0] sector_table_q;
	snap_t f_snap, q_snap;
	logic q_empty, q_pop, out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pole_pairs_q <= PolePairsReset;
			angle_step_q <= AngleStepReset;
			sector_table_q <= SectorTableReset;
		end else if (cfg_we) begin
			case (cfg_index)
				RegPolePairs:   pole_pairs_q <= cfg_data[7:0];
				RegAngleStep:   angle_step_q <= cfg_data[24:0];
				RegSectorTable: sector_table_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	hspd_front u_front (
		.clk, .arst_n, .in_valid(push && !full), .cmd, .hall_a, .hall_b, .hall_c,
		.now_us, .sector_table(sector_table_q), .snap(f_snap)
	);

	hspd_queue #(.Depth(QueueDepth)) u_queue (
		.clk, .arst_n, .wr(push), .wdata(f_snap), .full,
		.rd(q_pop), .empty(q_empty), .rdata(q_snap)
	);

	hspd_back u_back (
		.clk, .arst_n, .in_empty(q_empty), .in_snap(q_snap), .in_pop(q_pop),
		.pole_pairs(pole_pairs_q), .angle_step(angle_step_q),
		.out_valid, .out_pop(pop), .accepted, .sector, .turn_direction,
		.position_count, .whole_turns, .angle_q16, .velocity_q8, .edge_count
	);

	assign empty = !out_valid;

endmodule

### src/hspd_checker.sv
module hspd_checker import hspd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic empty,
	input  logic pop,
	input  logic accepted,
	input  logic [1:0] turn_direction,
	input  logic signed [VelW-1:0] velocity_q8,
	input  logic signed [AngW-1:0] angle_q16
);

	a_vel_dir: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && turn_direction == DirUnknown) |-> velocity_q8 == '0)
		else $error("velocity without direction");
	a_ang_rng: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (angle_q16 <= AngLimit && angle_q16 >= -AngLimit))
		else $error("angle out of range");
	a_acc_dir: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && accepted) |-> turn_direction != DirUnknown)
		else $error("accepted edge without direction");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("result dropped");

endmodule

bind hall_sensor_position_decoder_unit hspd_checker u_hspd_checker (
	.clk, .arst_n, .empty, .pop, .accepted, .turn_direction, .velocity_q8, .angle_q16
);
